// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the mosaic compositor RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== rtl/moc_pkg.sv =====
// Package for the mosaic compositor: commands, strategies, states, register indices.
// No dependencies.
package moc_pkg;
   typedef enum logic [1:0] {CMD_CLEAR = 2'd0, CMD_DEPOSIT = 2'd1, CMD_READ = 2'd2,
                             CMD_NONE = 2'd3} cmd_type;
   typedef enum logic [1:0] {STRAT_LAST = 2'd0, STRAT_RED = 2'd1, STRAT_MEAN = 2'd2,
                             STRAT_MEDIAN = 2'd3} strat_type;
   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_RD, ST_DEP, ST_MREAD, ST_MDIV, ST_MED_RD, ST_MED_SEL,
      ST_OUT
   } state_type;
   localparam int unsigned RegStrategy = 0;
   localparam int unsigned RegFillB = 1;
   localparam int unsigned RegFillG = 2;
   localparam int unsigned RegFillR = 3;
   localparam int unsigned RegWidth = 4;
   localparam int unsigned RegHeight = 5;
endpackage

// ===== rtl/mosaic_overlap_compositor_top.sv =====
// Top level of the mosaic compositor: frame memories, command sequencer, APB registers.
// Depends on moc_pkg, moc_divider and assert_macros.svh.
//
// channel | direction | beat
// req     | in        | cmd, target, flags, sample colour
// rsp     | out       | resolved colour, filled, overflowed
// csr     | in/out    | APB register access
//
// Deposit: a memory read, then a write back. Read: straight to output under strategies 0/1
// or for an empty pixel; for the mean one quotient bit a cycle on a shared divider, three
// channels in turn; for the median with n samples one sample read per slot and a select step
// per channel. Clear: one write per pixel of the w*h frame. After reset a clearing pass over
// all MAX_WIDTH*MAX_HEIGHT pixels zeroes counts and marks; no item is taken meanwhile.
// A stalled rsp beat holds the next read in its output state.
`include "assert_macros.svh"
module mosaic_overlap_compositor_top #(
   parameter int MAX_WIDTH = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_SAMPLES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_target_row,
   input  logic [5:0]  req_target_col,
   input  logic        req_in_frame,
   input  logic        req_source_nodata,
   input  logic        req_masked,
   input  logic [7:0]  req_sample_blue,
   input  logic [7:0]  req_sample_green,
   input  logic [7:0]  req_sample_red,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_red,
   output logic        rsp_filled,
   output logic        rsp_overflowed,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = (NPIX > 1) ? $clog2(NPIX) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int NCW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SUMW = 8 + NCW;
   localparam int NUMW = SUMW + 2;
   localparam int DENW = NCW + 1;
   localparam int SAW = AW + SW;

   // pixel record: colour, three sums, count, overflow mark
   typedef struct packed {
      logic [23:0]     colour;
      logic [SUMW-1:0] sum_r;
      logic [SUMW-1:0] sum_g;
      logic [SUMW-1:0] sum_b;
      logic [NCW-1:0]  count;
      logic            ovf;
   } pix_type;

   // registers
   logic [1:0] strat_ff;
   logic [7:0] fb_ff, fg_ff, fr_ff;
   logic [6:0] fw_ff, fh_ff;
   logic       wr_en;
   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         strat_ff <= '0;
         fb_ff <= '0;
         fg_ff <= '0;
         fr_ff <= '0;
         fw_ff <= 7'd64;
         fh_ff <= 7'd64;
      end else if (wr_en) begin
         unique case (paddr[4:2])
            3'(moc_pkg::RegStrategy): strat_ff <= pwdata[1:0];
            3'(moc_pkg::RegFillB):    fb_ff <= pwdata[7:0];
            3'(moc_pkg::RegFillG):    fg_ff <= pwdata[7:0];
            3'(moc_pkg::RegFillR):    fr_ff <= pwdata[7:0];
            3'(moc_pkg::RegWidth):    fw_ff <= pwdata[6:0];
            3'(moc_pkg::RegHeight):   fh_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (paddr[4:2])
         3'(moc_pkg::RegStrategy): prdata = {30'd0, strat_ff};
         3'(moc_pkg::RegFillB):    prdata = {24'd0, fb_ff};
         3'(moc_pkg::RegFillG):    prdata = {24'd0, fg_ff};
         3'(moc_pkg::RegFillR):    prdata = {24'd0, fr_ff};
         3'(moc_pkg::RegWidth):    prdata = {25'd0, fw_ff};
         3'(moc_pkg::RegHeight):   prdata = {25'd0, fh_ff};
         default:                  prdata = '0;
      endcase
   end

   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   always_comb begin
      if (fw_ff == '0) w_eff = WW'(1);
      else if (32'(fw_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(fw_ff);
      if (fh_ff == '0) h_eff = HW'(1);
      else if (32'(fh_ff) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(fh_ff);
   end
   logic [23:0] fill_col;
   assign fill_col = {fr_ff, fg_ff, fb_ff};

   // memories
   pix_type  pix_mem [NPIX];
   logic [23:0] smp_mem [NPIX * MAX_SAMPLES];
   logic        pix_we, smp_we;
   logic [AW-1:0]  pix_waddr, pix_raddr;
   pix_type     pix_wdata, pix_rdata;
   logic [SAW-1:0] smp_waddr, smp_raddr;
   logic [23:0] smp_wdata, smp_rdata;
   always_ff @(posedge clock) begin
      if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
      pix_rdata <= pix_mem[pix_raddr];
   end
   always_ff @(posedge clock) begin
      if (smp_we) smp_mem[smp_waddr] <= smp_wdata;
      smp_rdata <= smp_mem[smp_raddr];
   end

   // sequencer
   moc_pkg::state_type st_ff, st_in;
   logic          init_ff, init_in;
   logic [AW:0]   clr_ff, clr_in, clr_end_ff, clr_end_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          inside_ff, inside_in;
   logic          dep_ok_ff, dep_ok_in;
   logic [23:0]   samp_ff, samp_in;
   pix_type       cur_ff, cur_in;
   logic [1:0]    ch_ff, ch_in;
   logic [SW:0]   si_ff, si_in;
   logic [7:0]    mv_ff [MAX_SAMPLES];
   logic [7:0]    mv_in [MAX_SAMPLES];
   logic [23:0]   oc_ff, oc_in;
   logic          ofl_ff, ofl_in, oov_ff, oov_in;
   logic          rv_ff, rv_in;
   logic          dstart;
   logic [NUMW-1:0] dnum;
   logic [DENW-1:0] dden;
   logic          dbusy;
   logic [NUMW-1:0] dquot;
   logic          accept;
   logic          in_inside;
   logic [AW-1:0] in_addr;
   logic [7:0]    sel_val;
   logic [SUMW-1:0] sel_sum;
   logic [NCW:0]  rank_lt, rank_le;
   logic [NCW-1:0] mid;

   assign in_inside = (HW'(req_target_row) < h_eff) && (WW'(req_target_col) < w_eff)
                      && (32'(req_target_row) < MAX_HEIGHT)
                      && (32'(req_target_col) < MAX_WIDTH);
   assign in_addr = AW'(32'(req_target_row) * 32'(w_eff) + 32'(req_target_col));
   assign accept = req_valid && !req_stall;
   assign req_stall = (st_ff != moc_pkg::ST_IDLE) || !init_ff;
   assign mid = NCW'((cur_ff.count - 1'b1) >> 1);

   moc_divider #(.NW(NUMW), .DW(DENW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .busy(dbusy), .quot(dquot)
   );

   always_comb begin
      unique case (ch_ff)
         2'd0: sel_sum = cur_ff.sum_b;
         2'd1: sel_sum = cur_ff.sum_g;
         default: sel_sum = cur_ff.sum_r;
      endcase
      dnum = NUMW'({sel_sum, 1'b0}) + NUMW'(cur_ff.count);
      dden = {cur_ff.count, 1'b0};
   end

   always_comb begin
      sel_val = mv_ff[0];
      for (int i = MAX_SAMPLES - 1; i >= 0; i--) begin
         rank_lt = '0;
         rank_le = '0;
         for (int j = 0; j < MAX_SAMPLES; j++) begin
            if (NCW'(j) < cur_ff.count) begin
               if (mv_ff[j] < mv_ff[i]) rank_lt = rank_lt + 1'b1;
               if (mv_ff[j] <= mv_ff[i]) rank_le = rank_le + 1'b1;
            end
         end
         if (NCW'(i) < cur_ff.count && (NCW + 1)'(mid) >= rank_lt
             && (NCW + 1)'(mid) < rank_le) sel_val = mv_ff[i];
      end
   end

   always_comb begin
      st_in = st_ff;
      init_in = init_ff;
      clr_in = clr_ff;
      clr_end_in = clr_end_ff;
      addr_in = addr_ff;
      inside_in = inside_ff;
      dep_ok_in = dep_ok_ff;
      samp_in = samp_ff;
      cur_in = cur_ff;
      ch_in = ch_ff;
      si_in = si_ff;
      mv_in = mv_ff;
      oc_in = oc_ff;
      ofl_in = ofl_ff;
      oov_in = oov_ff;
      rv_in = rv_ff;
      pix_we = 1'b0;
      pix_waddr = AW'(clr_ff);
      pix_wdata = '0;
      pix_wdata.colour = fill_col;
      pix_raddr = in_addr;
      smp_we = 1'b0;
      smp_waddr = {addr_ff, SW'(cur_ff.count)};
      smp_wdata = samp_ff;
      smp_raddr = {addr_ff, si_ff[SW-1:0]};
      dstart = 1'b0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      if (!init_ff) begin
         pix_we = 1'b1;
         clr_in = clr_ff + 1'b1;
         if (clr_ff == (AW + 1)'(NPIX - 1)) init_in = 1'b1;
      end
      unique case (st_ff)
         moc_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in = in_addr;
               inside_in = in_inside;
               samp_in = {req_sample_red, req_sample_green, req_sample_blue};
               dep_ok_in = in_inside && req_in_frame && !req_source_nodata
                           && !(strat_ff[1] && req_masked);
               unique case (moc_pkg::cmd_type'(req_cmd))
                  moc_pkg::CMD_CLEAR: begin
                     clr_in = '0;
                     clr_end_in = (AW + 1)'(32'(w_eff) * 32'(h_eff));
                     st_in = moc_pkg::ST_CLEAR;
                  end
                  moc_pkg::CMD_DEPOSIT: st_in = moc_pkg::ST_RD;
                  moc_pkg::CMD_READ:    st_in = moc_pkg::ST_MREAD;
                  default: ;
               endcase
            end
         end
         moc_pkg::ST_CLEAR: begin
            if (clr_ff == clr_end_ff) begin
               st_in = moc_pkg::ST_IDLE;
            end else begin
               pix_we = 1'b1;
               clr_in = clr_ff + 1'b1;
            end
         end
         moc_pkg::ST_RD: begin
            pix_raddr = addr_ff;
            st_in = moc_pkg::ST_DEP;
         end
         moc_pkg::ST_DEP: begin
            st_in = moc_pkg::ST_IDLE;
            pix_waddr = addr_ff;
            pix_wdata = pix_rdata;
            smp_waddr = {addr_ff, SW'(pix_rdata.count)};
            if (dep_ok_ff) begin
               pix_we = 1'b1;
               if (32'(pix_rdata.count) < MAX_SAMPLES) begin
                  smp_we = 1'b1;
                  pix_wdata.sum_b = pix_rdata.sum_b + SUMW'(samp_ff[7:0]);
                  pix_wdata.sum_g = pix_rdata.sum_g + SUMW'(samp_ff[15:8]);
                  pix_wdata.sum_r = pix_rdata.sum_r + SUMW'(samp_ff[23:16]);
                  pix_wdata.count = pix_rdata.count + 1'b1;
               end else if (strat_ff[1]) begin
                  pix_wdata.ovf = 1'b1;
               end
               if (moc_pkg::strat_type'(strat_ff) == moc_pkg::STRAT_LAST) begin
                  pix_wdata.colour = samp_ff;
               end else if (moc_pkg::strat_type'(strat_ff) == moc_pkg::STRAT_RED) begin
                  pix_wdata.colour = (pix_rdata.count == '0) ? samp_ff : 24'hFF0000;
               end
            end
         end
         moc_pkg::ST_MREAD: begin
            cur_in = pix_rdata;
            ch_in = '0;
            si_in = '0;
            oc_in = fill_col;
            ofl_in = 1'b0;
            oov_in = inside_ff && pix_rdata.ovf;
            st_in = moc_pkg::ST_OUT;
            if (inside_ff && pix_rdata.count != '0) begin
               ofl_in = 1'b1;
               if (!strat_ff[1]) begin
                  oc_in = pix_rdata.colour;
               end else if (moc_pkg::strat_type'(strat_ff) == moc_pkg::STRAT_MEAN) begin
                  st_in = moc_pkg::ST_MDIV;
               end else begin
                  st_in = moc_pkg::ST_MED_RD;
               end
            end
            if (st_in == moc_pkg::ST_MDIV) dstart = 1'b0;
         end
         moc_pkg::ST_MDIV: begin
            if (!dbusy && si_ff == '0) begin
               dstart = 1'b1;
               si_in = (SW + 1)'(1);
            end else if (!dbusy) begin
               unique case (ch_ff)
                  2'd0: oc_in[7:0] = dquot[7:0];
                  2'd1: oc_in[15:8] = dquot[7:0];
                  default: oc_in[23:16] = dquot[7:0];
               endcase
               si_in = '0;
               ch_in = ch_ff + 1'b1;
               if (ch_ff == 2'd2) st_in = moc_pkg::ST_OUT;
            end
         end
         moc_pkg::ST_MED_RD: begin
            if (NCW'(si_ff) < cur_ff.count) begin
               si_in = si_ff + 1'b1;
            end
            if (si_ff != '0) begin
               unique case (ch_ff)
                  2'd0: mv_in[si_ff[SW-1:0] - 1'b1] = smp_rdata[7:0];
                  2'd1: mv_in[si_ff[SW-1:0] - 1'b1] = smp_rdata[15:8];
                  default: mv_in[si_ff[SW-1:0] - 1'b1] = smp_rdata[23:16];
               endcase
            end
            if (si_ff == (SW + 1)'(cur_ff.count)) st_in = moc_pkg::ST_MED_SEL;
         end
         moc_pkg::ST_MED_SEL: begin
            unique case (ch_ff)
               2'd0: oc_in[7:0] = sel_val;
               2'd1: oc_in[15:8] = sel_val;
               default: oc_in[23:16] = sel_val;
            endcase
            si_in = '0;
            ch_in = ch_ff + 1'b1;
            st_in = (ch_ff == 2'd2) ? moc_pkg::ST_OUT : moc_pkg::ST_MED_RD;
         end
         moc_pkg::ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               st_in = moc_pkg::ST_IDLE;
            end
         end
         default: st_in = moc_pkg::ST_IDLE;
      endcase
   end

   logic [23:0] ro_col_ff;
   logic        ro_fl_ff, ro_ov_ff;
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      inside_ff <= inside_in;
      dep_ok_ff <= dep_ok_in;
      samp_ff <= samp_in;
      cur_ff <= cur_in;
      mv_ff <= mv_in;
      oc_ff <= oc_in;
      ofl_ff <= ofl_in;
      oov_ff <= oov_in;
      clr_end_ff <= clr_end_in;
      if (st_ff == moc_pkg::ST_OUT && (!rv_ff || !rsp_stall)) begin
         ro_col_ff <= oc_ff;
         ro_fl_ff <= ofl_ff;
         ro_ov_ff <= oov_ff;
      end
      if (reset) begin
         st_ff <= moc_pkg::ST_IDLE;
         init_ff <= 1'b0;
         clr_ff <= '0;
         ch_ff <= '0;
         si_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         init_ff <= init_in;
         clr_ff <= clr_in;
         ch_ff <= ch_in;
         si_ff <= si_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_out_blue = ro_col_ff[7:0];
   assign rsp_out_green = ro_col_ff[15:8];
   assign rsp_out_red = ro_col_ff[23:16];
   assign rsp_filled = ro_fl_ff;
   assign rsp_overflowed = ro_ov_ff;

   `ASSERT_IMPL(a_no_accept_init, clock, reset, !init_ff, !accept)
   `ASSERT_NEXT(a_dep_path, clock, reset, st_ff == moc_pkg::ST_RD, st_ff == moc_pkg::ST_DEP)
   `ASSERT_IMPL(a_fill_ovf, clock, reset, rv_ff && ro_ov_ff, ro_fl_ff)
   `ASSERT_IMPL(a_smp_we, clock, reset, smp_we, st_ff == moc_pkg::ST_DEP)
endmodule

// ===== rtl/moc_divider.sv =====
// Restoring divider for the mean: quotient = num / den, one bit a cycle.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module moc_divider #(
   parameter int NW = 16,
   parameter int DW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign quot = q_ff;

   `ASSERT_IMPL(a_div_cnt, clock, reset, busy_ff, cnt_ff != '0)
   `ASSERT_NEXT(a_div_start, clock, reset, start, busy_ff)
endmodule
